>>> rtl/render_offset_decay_table_defines.svh
// ----------------------------------------------------------------------------
// render offset decay table assertion macros
// shared immediate-implication and next-cycle checks on clk, reset by arst_n
// ----------------------------------------------------------------------------
`ifndef RENDER_OFFSET_DECAY_TABLE_DEFINES_SVH
`define RENDER_OFFSET_DECAY_TABLE_DEFINES_SVH

// same-cycle implication
`define RODT_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("render offset table check failed");

// next-cycle implication
`define RODT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("render offset table check failed");

`endif

>>> rtl/rodt_pkg.sv
// ----------------------------------------------------------------------------
// rodt_pkg
// shared types and constants of the render offset decay table
// ----------------------------------------------------------------------------
package rodt_pkg;

	localparam int S_TDATA_W = 240;
	localparam int M_TDATA_W = 120;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic ST_DONE   = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_SET     = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_READ    = 2'd3
	} opcode_t;

	// one table entry, x offset in the lowest bits
	typedef struct packed {
		logic [7:0]  ticks;
		logic [13:0] heading;
		logic [31:0] oz;
		logic [31:0] oy;
		logic [31:0] ox;
	} row_t;

	localparam int ROW_W = $bits(row_t);

endpackage

>>> rtl/rodt_decay.sv
// ----------------------------------------------------------------------------
// rodt_decay
// one decay lane: round(v * (n-1) / n) ties away from zero, radix-2 divider
// ----------------------------------------------------------------------------
module rodt_decay
	import rodt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] value,
	input  logic [7:0]  n,
	output logic        done,
	output logic [31:0] result
);

	logic                 run_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [31:0]          mag_q;
	logic [31:0]          dvd_q;
	logic [31:0]          quot_q;
	logic [7:0]           rem_q;
	logic [7:0]           n_q;

	logic [31:0] mag_in;
	logic [8:0]  trial;
	logic        fit;
	logic        round_up;
	logic [31:0] adj;

	assign mag_in = value[31] ? (~value + 32'd1) : value;
	assign trial  = {rem_q, dvd_q[31]};
	assign fit    = trial >= {1'b0, n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= DIV_CNT_W'(DIV_STEPS);
		end else if (run_q && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= value[31];
			mag_q  <= mag_in;
			dvd_q  <= mag_in;
			quot_q <= '0;
			rem_q  <= '0;
			n_q    <= n;
		end else if (run_q && cnt_q != '0) begin
			dvd_q  <= {dvd_q[30:0], 1'b0};
			quot_q <= {quot_q[30:0], fit};
			rem_q  <= fit ? 8'(trial - {1'b0, n_q}) : trial[7:0];
		end
	end

	// m - m/n rounded: subtract quotient, one more when remainder is past half
	assign round_up = {rem_q, 1'b0} > {1'b0, n_q};
	assign adj      = quot_q + {31'd0, round_up};
	assign result   = neg_q ? (adj - mag_q) : (mag_q - adj);
	assign done     = run_q && (cnt_q == '0);

endmodule

>>> rtl/rodt_mem.sv
// ----------------------------------------------------------------------------
// rodt_mem
// entry memory, one row per entity, registered read, per-row valid bits
// ----------------------------------------------------------------------------
module rodt_mem
	import rodt_pkg::*;
#(
	parameter int ENTRY_COUNT = 16,
	localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output row_t             rd_row,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  row_t             wr_row
);

	row_t                   mem_q [ENTRY_COUNT];
	logic [ENTRY_COUNT-1:0] valid_q;
	row_t                   rd_row_s1;
	logic                   rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	// a row never written since reset reads as zero
	assign rd_row = rd_vld_s1 ? rd_row_s1 : '0;

endmodule

>>> rtl/render_offset_decay_table.sv
// ----------------------------------------------------------------------------
// render_offset_decay_table
// per-entity render correction offsets that decay linearly to zero
// ----------------------------------------------------------------------------
// One item in, one result out. Clear and set go from acceptance through the
// result state back to idle; read also passes a wait state for the registered
// memory read. Advance walks the table one entry at a time through the row
// memory: an entry with count 0 or 1 is read and checked, while for a decaying
// entry four radix-2 divider lanes (x, y, z, yaw) compute m / n side by side;
// the item ends in the result state. The table is cleared at reset through
// per-row valid bits, with no clearing pass. A result waits in the output
// register while the next item is taken.
module render_offset_decay_table
	import rodt_pkg::*;
#(
	parameter int ENTRY_COUNT = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// entity, before_x, before_y, before_z, after_x, after_y, after_z,
	// before_heading, after_heading, span, zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// opcode
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// offset_x, offset_y, offset_z, heading_offset, ticks_left, zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	// status
	output logic [0:0]           m_tuser
);

	localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_WAIT,
		S_ADV_RD,
		S_ADV_CHK,
		S_ADV_DIV,
		S_RESULT
	} state_t;

	function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) begin
			sat_sub = d[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			sat_sub = d[31:0];
		end
	endfunction

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	row_t             res_row_q;
	logic             res_status_q;
	logic             m_tvalid_q;
	row_t             m_row_q;
	logic             m_status_q;

	opcode_t     op;
	logic [7:0]  entity;
	logic [31:0] before_x, before_y, before_z;
	logic [31:0] after_x, after_y, after_z;
	logic [13:0] before_heading, after_heading;
	logic [7:0]  span;
	logic        accept;
	logic        bad;
	logic [IDX_W-1:0] ent_idx;
	row_t        set_row;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	row_t             rd_row;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	row_t             wr_row;

	logic        dec_start;
	logic [3:0]  dec_done;
	logic [31:0] dec_x, dec_y, dec_z, dec_h;
	logic        lanes_done;
	logic        last_entry;

	assign op             = opcode_t'(s_tuser);
	assign entity         = s_tdata[7:0];
	assign before_x       = s_tdata[39:8];
	assign before_y       = s_tdata[71:40];
	assign before_z       = s_tdata[103:72];
	assign after_x        = s_tdata[135:104];
	assign after_y        = s_tdata[167:136];
	assign after_z        = s_tdata[199:168];
	assign before_heading = s_tdata[213:200];
	assign after_heading  = s_tdata[227:214];
	assign span           = s_tdata[235:228];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign bad      = ({1'b0, entity} >= 9'(ENTRY_COUNT)) || (op == OP_SET && span == 8'd0);
	assign ent_idx  = entity[IDX_W-1:0];

	// yaw difference on the 14-bit circle is already the signed wrapped value
	always_comb begin
		set_row.ox      = sat_sub(before_x, after_x);
		set_row.oy      = sat_sub(before_y, after_y);
		set_row.oz      = sat_sub(before_z, after_z);
		set_row.heading = before_heading - after_heading;
		set_row.ticks   = span;
	end

	assign lanes_done = &dec_done;
	assign last_entry = (idx_q == IDX_W'(ENTRY_COUNT - 1));

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_row    = '0;
		dec_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && op != OP_ADVANCE && !bad) begin
					case (op)
						OP_CLEAR: begin
							wr_en   = 1'b1;
							wr_addr = ent_idx;
						end
						OP_SET: begin
							wr_en   = 1'b1;
							wr_addr = ent_idx;
							wr_row  = set_row;
						end
						OP_READ: begin
							rd_en   = 1'b1;
							rd_addr = ent_idx;
						end
						default: ;
					endcase
				end
			end
			S_ADV_RD: begin
				rd_en = 1'b1;
			end
			S_ADV_CHK: begin
				if (rd_row.ticks == 8'd1) begin
					wr_en = 1'b1;
				end else if (rd_row.ticks > 8'd1) begin
					dec_start = 1'b1;
				end
			end
			S_ADV_DIV: begin
				if (lanes_done) begin
					wr_en          = 1'b1;
					wr_row.ox      = dec_x;
					wr_row.oy      = dec_y;
					wr_row.oz      = dec_z;
					wr_row.heading = dec_h[13:0];
					wr_row.ticks   = rd_row.ticks - 8'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			res_row_q    <= '0;
			res_status_q <= ST_DONE;
			m_tvalid_q   <= 1'b0;
			m_row_q      <= '0;
			m_status_q   <= ST_DONE;
		end else begin
			// the result state reloads the output register itself
			if (m_tready && state_q != S_RESULT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_row_q    <= '0;
						res_status_q <= ST_DONE;
						if (op == OP_ADVANCE) begin
							idx_q   <= '0;
							state_q <= S_ADV_RD;
						end else if (bad) begin
							res_status_q <= ST_REJECT;
							state_q      <= S_RESULT;
						end else begin
							case (op)
								OP_SET: begin
									res_row_q <= set_row;
									state_q   <= S_RESULT;
								end
								OP_READ: begin
									state_q <= S_RD_WAIT;
								end
								default: begin
									state_q <= S_RESULT;
								end
							endcase
						end
					end
				end
				S_RD_WAIT: begin
					res_row_q <= rd_row;
					state_q   <= S_RESULT;
				end
				S_ADV_RD: begin
					state_q <= S_ADV_CHK;
				end
				S_ADV_CHK: begin
					if (rd_row.ticks > 8'd1) begin
						state_q <= S_ADV_DIV;
					end else if (last_entry) begin
						state_q <= S_RESULT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_ADV_RD;
					end
				end
				S_ADV_DIV: begin
					if (lanes_done) begin
						if (last_entry) begin
							state_q <= S_RESULT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_ADV_RD;
						end
					end
				end
				S_RESULT: begin
					if (!m_tvalid_q || m_tready) begin
						m_row_q    <= res_row_q;
						m_status_q <= res_status_q;
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - ROW_W){1'b0}}, m_row_q};
	assign m_tuser  = m_status_q;

	rodt_mem #(
		.ENTRY_COUNT(ENTRY_COUNT)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_row (rd_row),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_row (wr_row)
	);

	rodt_decay u_dec_x (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dec_start),
		.value (rd_row.ox),
		.n     (rd_row.ticks),
		.done  (dec_done[0]),
		.result(dec_x)
	);

	rodt_decay u_dec_y (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dec_start),
		.value (rd_row.oy),
		.n     (rd_row.ticks),
		.done  (dec_done[1]),
		.result(dec_y)
	);

	rodt_decay u_dec_z (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dec_start),
		.value (rd_row.oz),
		.n     (rd_row.ticks),
		.done  (dec_done[2]),
		.result(dec_z)
	);

	rodt_decay u_dec_h (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dec_start),
		.value ({{18{rd_row.heading[13]}}, rd_row.heading}),
		.n     (rd_row.ticks),
		.done  (dec_done[3]),
		.result(dec_h)
	);

endmodule

>>> rtl/rodt_checker.sv
// ----------------------------------------------------------------------------
// rodt_checker
// port-level checks of the render offset decay table, bound to the top level
// ----------------------------------------------------------------------------
`include "render_offset_decay_table_defines.svh"

module rodt_checker
	import rodt_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [0:0]           m_tuser
);

	// a stalled result holds
	`RODT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// one item at a time: input closes right after an acceptance
	`RODT_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

	// a rejected item reports an all-zero entry
	`RODT_ASSERT_IMPLY(a_reject_zero, m_tvalid && m_tuser[0], m_tdata == '0)

	// an entry with no ticks left holds no offset
	`RODT_ASSERT_IMPLY(a_idle_entry_zero, m_tvalid && m_tdata[117:110] == 8'd0, m_tdata[119:0] == '0)

endmodule

bind render_offset_decay_table rodt_checker u_rodt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
